// ===== design/assert_macros.svh =====
// Assertion helpers used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KZA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KZA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/kza_pkg.sv =====
package kza_pkg;

    localparam logic [1:0] CMD_NOTE_ON    = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF   = 2'd1;
    localparam logic [1:0] CMD_VOICE_DONE = 2'd2;
    localparam logic [1:0] CMD_WRITE_ZONE = 2'd3;

    localparam logic REG_VOICES_IN_USE = 1'b0;
    localparam logic REG_ZONES_IN_USE  = 1'b1;

    localparam int         CFG_W         = 5;
    localparam logic [4:0] VOICES_RESET  = 5'd16;
    localparam logic [4:0] ZONES_RESET   = 5'd0;

    // floor(x / 127) == (x * GAIN_RECIP) >> GAIN_SHIFT for every x below 2^23.
    localparam logic [23:0] GAIN_RECIP = 24'd8454661;
    localparam int          GAIN_SHIFT = 30;

    typedef struct packed {
        logic [6:0]  low;
        logic [6:0]  high;
        logic [6:0]  root;
        logic [15:0] gain;
        logic        src;
    } t_zone;

    typedef struct packed {
        logic  valid;
        logic  found;
        t_zone zone;
    } t_ztok;

    typedef struct packed {
        logic        valid;
        logic        any;
        logic        idle;
        logic [31:0] age;
    } t_vtok;

    typedef struct packed {
        logic set;
        logic clr;
        logic off;
    } t_vcmd;

endpackage

// ===== design/kza_in_if.sv =====
interface kza_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [3:0]  finished_voice;
    logic [3:0]  zone_slot;
    logic [6:0]  zone_low_note;
    logic [6:0]  zone_high_note;
    logic [6:0]  zone_root_note;
    logic [15:0] zone_gain_in;
    logic        zone_has_source;

    modport source (
        output valid, command, note, velocity, finished_voice, zone_slot,
               zone_low_note, zone_high_note, zone_root_note, zone_gain_in,
               zone_has_source,
        input  ready
    );

    modport sink (
        input  valid, command, note, velocity, finished_voice, zone_slot,
               zone_low_note, zone_high_note, zone_root_note, zone_gain_in,
               zone_has_source,
        output ready
    );
endinterface

// ===== design/kza_out_if.sv =====
interface kza_out_if;
    logic              valid;
    logic              ready;
    logic              started;
    logic              stolen;
    logic [3:0]        voice_out;
    logic [3:0]        zone_out;
    logic signed [7:0] semitone_offset;
    logic [15:0]       voice_gain;
    logic [15:0]       stopped_mask;
    logic [4:0]        active_count;

    modport source (
        output valid, started, stolen, voice_out, zone_out, semitone_offset,
               voice_gain, stopped_mask, active_count,
        input  ready
    );

    modport sink (
        input  valid, started, stolen, voice_out, zone_out, semitone_offset,
               voice_gain, stopped_mask, active_count,
        output ready
    );
endinterface

// ===== design/kza_zone_cell.sv =====
module kza_zone_cell #(
    parameter int ZIW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  kza_pkg::t_zone       i_wr_zone,
    input  logic                 i_in_use,
    input  logic [6:0]           i_note,
    input  logic [ZIW-1:0]       i_index,
    input  kza_pkg::t_ztok       i_tok,
    input  logic [ZIW-1:0]       i_tok_idx,
    output kza_pkg::t_ztok       o_tok,
    output logic [ZIW-1:0]       o_tok_idx
);

    kza_pkg::t_zone r_zone;
    kza_pkg::t_ztok r_tok;
    logic [ZIW-1:0] r_idx;
    kza_pkg::t_ztok n_tok;
    logic [ZIW-1:0] n_idx;
    logic           w_hit;
    logic           w_better;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_zone <= i_wr_zone;
        end
    end

    assign w_hit    = i_in_use && (i_note >= r_zone.low) && (i_note <= r_zone.high);
    assign w_better = !i_tok.found ||
                      ((r_zone.high - r_zone.low) < (i_tok.zone.high - i_tok.zone.low));

    always_comb begin
        n_tok = i_tok;
        n_idx = i_tok_idx;
        if (w_hit && w_better) begin
            n_tok.found = 1'b1;
            n_tok.zone  = r_zone;
            n_idx       = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_idx <= '0;
        end else begin
            r_tok <= n_tok;
            r_idx <= n_idx;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_idx;

endmodule

// ===== design/kza_voice_cell.sv =====
module kza_voice_cell #(
    parameter int VIW = 4,
    parameter int CW  = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_use,
    input  logic [VIW-1:0]       i_index,
    input  logic [6:0]           i_note,
    input  logic [31:0]          i_age,
    input  kza_pkg::t_vcmd       i_cmd,
    input  kza_pkg::t_vtok       i_tok,
    input  logic [VIW-1:0]       i_tok_idx,
    input  logic [CW-1:0]        i_tok_cnt,
    output kza_pkg::t_vtok       o_tok,
    output logic [VIW-1:0]       o_tok_idx,
    output logic [CW-1:0]        o_tok_cnt,
    output logic                 o_off_hit
);

    logic [6:0]     r_note;
    logic           r_active;
    logic [31:0]    r_age;
    kza_pkg::t_vtok r_tok;
    logic [VIW-1:0] r_idx;
    logic [CW-1:0]  r_cnt;
    kza_pkg::t_vtok n_tok;
    logic [VIW-1:0] n_idx;
    logic [CW-1:0]  n_cnt;

    assign o_off_hit = i_in_use && r_active && (r_note == i_note);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note   <= '0;
            r_active <= 1'b0;
            r_age    <= '0;
        end else if (i_cmd.set) begin
            r_note   <= i_note;
            r_active <= 1'b1;
            r_age    <= i_age;
        end else if (i_cmd.clr || (i_cmd.off && o_off_hit)) begin
            r_active <= 1'b0;
        end
    end

    // An idle voice wins outright; otherwise the strictly older voice replaces the candidate.
    always_comb begin
        n_tok = i_tok;
        n_idx = i_tok_idx;
        n_cnt = i_tok_cnt;
        if (i_in_use) begin
            n_cnt = i_tok_cnt + CW'(r_active);
            if (!i_tok.idle) begin
                if (!r_active) begin
                    n_tok.idle = 1'b1;
                    n_tok.any  = 1'b1;
                    n_idx      = i_index;
                end else if (!i_tok.any || (r_age < i_tok.age)) begin
                    n_tok.any = 1'b1;
                    n_tok.age = r_age;
                    n_idx     = i_index;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            r_tok <= n_tok;
            r_idx <= n_idx;
            r_cnt <= n_cnt;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_idx;
    assign o_tok_cnt = r_cnt;

endmodule

// ===== design/keyzone_voice_allocator_core.sv =====
// Note-on items pass their token through the zone cells and then the voice cells; other
// commands pass through the voice cells only. One item at a time: the input is not ready
// again until the result has been registered on o_out, which waits on o_out.ready while
// an earlier result is still held there.
// Synchronous reset clears all voices, the age counter and the pipeline, and restores
// the registers to their defaults; zone entries hold no value until written.
`include "assert_macros.svh"

module keyzone_voice_allocator_core #(
    parameter int VOICES = 16,
    parameter int ZONES  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kza_in_if.sink       i_in,
    kza_out_if.source    o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ZIW = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CW  = $clog2(VOICES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ZONE  = 2'd1;
    localparam logic [1:0] S_VOICE = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]        r_state;
    logic [4:0]        r_cfg_voices;
    logic [4:0]        r_cfg_zones;
    logic [1:0]        r_cmd;
    logic [6:0]        r_note;
    logic [6:0]        r_vel;
    logic              r_zstart;
    logic              r_vstart;
    logic              r_zfound;
    logic [ZIW-1:0]    r_zidx;
    logic [6:0]        r_zroot;
    logic [22:0]       r_prod;
    logic [15:0]       r_gain;
    logic [31:0]       r_age_ctr;
    logic [15:0]       r_mask;
    logic              r_res_started;
    logic              r_res_stolen;
    logic [3:0]        r_res_voice;
    logic [3:0]        r_res_zone;
    logic [7:0]        r_res_offset;
    logic [4:0]        r_res_count;
    logic              r_ovalid;
    logic              r_o_started;
    logic              r_o_stolen;
    logic [3:0]        r_o_voice;
    logic [3:0]        r_o_zone;
    logic [7:0]        r_o_offset;
    logic [15:0]       r_o_gain;
    logic [15:0]       r_o_mask;
    logic [4:0]        r_o_count;

    logic              w_acc;
    logic              w_cfg_wr;
    logic              w_zdone;
    logic              w_vdone;
    logic              w_start;
    logic [31:0]       w_age_next;
    logic [46:0]       w_gprod;
    logic [6:0]        w_vnote;
    logic [15:0]       w_mask;
    logic [VOICES-1:0] w_vuse;
    logic [VOICES-1:0] w_off_hit;
    logic [ZONES-1:0]  w_zuse;
    kza_pkg::t_zone    w_wr_zone;

    kza_pkg::t_ztok    w_ztok [ZONES];
    logic [ZIW-1:0]    w_zidx [ZONES];
    kza_pkg::t_vtok    w_vtok [VOICES];
    logic [VIW-1:0]    w_vidx [VOICES];
    logic [CW-1:0]     w_vcnt [VOICES];

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_voices <= kza_pkg::VOICES_RESET;
            r_cfg_zones  <= kza_pkg::ZONES_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                kza_pkg::REG_VOICES_IN_USE: r_cfg_voices <= pwdata[kza_pkg::CFG_W-1:0];
                kza_pkg::REG_ZONES_IN_USE:  r_cfg_zones  <= pwdata[kza_pkg::CFG_W-1:0];
                default:                    r_cfg_voices <= r_cfg_voices;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            kza_pkg::REG_VOICES_IN_USE: prdata = {27'd0, r_cfg_voices};
            kza_pkg::REG_ZONES_IN_USE:  prdata = {27'd0, r_cfg_zones};
            default:                    prdata = '0;
        endcase
    end

    // Input handshake and command decode.
    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && (r_state == S_IDLE);
    assign w_zdone    = w_ztok[ZONES-1].valid;
    assign w_vdone    = w_vtok[VOICES-1].valid;
    assign w_start    = (r_cmd == kza_pkg::CMD_NOTE_ON) && r_zfound;
    assign w_age_next = r_age_ctr + 32'd1;
    assign w_vnote    = (r_state == S_IDLE) ? i_in.note : r_note;
    assign w_gprod    = 47'(r_prod) * 47'(kza_pkg::GAIN_RECIP);

    assign w_wr_zone = '{low:  i_in.zone_low_note,
                         high: i_in.zone_high_note,
                         root: i_in.zone_root_note,
                         gain: i_in.zone_gain_in,
                         src:  i_in.zone_has_source};

    // Zone cells.
    for (genvar j = 0; j < ZONES; j++) begin : g_zone
        kza_pkg::t_ztok w_tin;
        logic [ZIW-1:0] w_iin;
        logic           w_wr;

        assign w_zuse[j] = (32'(r_cfg_zones) > 32'(j));
        assign w_wr      = w_acc && (i_in.command == kza_pkg::CMD_WRITE_ZONE) &&
                           (32'(i_in.zone_slot) == 32'(j));

        if (j == 0) begin : g_head
            assign w_tin = '{valid: r_zstart, found: 1'b0, zone: '0};
            assign w_iin = '0;
        end else begin : g_link
            assign w_tin = w_ztok[j-1];
            assign w_iin = w_zidx[j-1];
        end

        kza_zone_cell #(.ZIW(ZIW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr      (w_wr),
            .i_wr_zone (w_wr_zone),
            .i_in_use  (w_zuse[j]),
            .i_note    (r_note),
            .i_index   (ZIW'(j)),
            .i_tok     (w_tin),
            .i_tok_idx (w_iin),
            .o_tok     (w_ztok[j]),
            .o_tok_idx (w_zidx[j])
        );
    end

    // Voice cells.
    for (genvar i = 0; i < VOICES; i++) begin : g_voice
        kza_pkg::t_vtok w_tin;
        logic [VIW-1:0] w_iin;
        logic [CW-1:0]  w_cin;
        kza_pkg::t_vcmd w_cmd;

        assign w_vuse[i] = (i == 0) || (32'(r_cfg_voices) > 32'(i));
        assign w_cmd.set = (r_state == S_VOICE) && w_vdone && w_start &&
                           (w_vidx[VOICES-1] == VIW'(i));
        assign w_cmd.clr = w_acc && (i_in.command == kza_pkg::CMD_VOICE_DONE) &&
                           w_vuse[i] && (32'(i_in.finished_voice) == 32'(i));
        assign w_cmd.off = w_acc && (i_in.command == kza_pkg::CMD_NOTE_OFF);

        if (i == 0) begin : g_head
            assign w_tin = '{valid: r_vstart, any: 1'b0, idle: 1'b0, age: '0};
            assign w_iin = '0;
            assign w_cin = '0;
        end else begin : g_link
            assign w_tin = w_vtok[i-1];
            assign w_iin = w_vidx[i-1];
            assign w_cin = w_vcnt[i-1];
        end

        kza_voice_cell #(.VIW(VIW), .CW(CW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_in_use  (w_vuse[i]),
            .i_index   (VIW'(i)),
            .i_note    (w_vnote),
            .i_age     (w_age_next),
            .i_cmd     (w_cmd),
            .i_tok     (w_tin),
            .i_tok_idx (w_iin),
            .i_tok_cnt (w_cin),
            .o_tok     (w_vtok[i]),
            .o_tok_idx (w_vidx[i]),
            .o_tok_cnt (w_vcnt[i]),
            .o_off_hit (w_off_hit[i])
        );
    end

    for (genvar k = 0; k < 16; k++) begin : g_mask
        if (k < VOICES) begin : g_bit
            assign w_mask[k] = w_off_hit[k];
        end else begin : g_zero
            assign w_mask[k] = 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_zstart  <= 1'b0;
            r_vstart  <= 1'b0;
            r_age_ctr <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_zstart <= w_acc && (i_in.command == kza_pkg::CMD_NOTE_ON);
            r_vstart <= (w_acc && (i_in.command != kza_pkg::CMD_NOTE_ON)) ||
                        ((r_state == S_ZONE) && w_zdone);
            if ((r_state == S_VOICE) && w_vdone && w_start) begin
                r_age_ctr <= w_age_next;
            end
            if (o_out.ready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= (i_in.command == kza_pkg::CMD_NOTE_ON) ? S_ZONE : S_VOICE;
                    end
                end
                S_ZONE: begin
                    if (w_zdone) begin
                        r_state <= S_VOICE;
                    end
                end
                S_VOICE: begin
                    if (w_vdone) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item and result payload.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd  <= i_in.command;
            r_note <= i_in.note;
            r_vel  <= i_in.velocity;
            r_mask <= (i_in.command == kza_pkg::CMD_NOTE_OFF) ? w_mask : '0;
        end
        if ((r_state == S_IDLE) && w_acc) begin
            r_zfound <= 1'b0;
        end else if ((r_state == S_ZONE) && w_zdone) begin
            r_zfound <= w_ztok[ZONES-1].found && w_ztok[ZONES-1].zone.src;
            r_zidx   <= w_zidx[ZONES-1];
            r_zroot  <= w_ztok[ZONES-1].zone.root;
            r_prod   <= 23'(w_ztok[ZONES-1].zone.gain) * 23'(r_vel);
        end
        r_gain <= w_gprod[kza_pkg::GAIN_SHIFT+15:kza_pkg::GAIN_SHIFT];
        if ((r_state == S_VOICE) && w_vdone) begin
            r_res_started <= w_start;
            r_res_stolen  <= w_start && !w_vtok[VOICES-1].idle;
            r_res_voice   <= w_start ? 4'(w_vidx[VOICES-1]) : 4'd0;
            r_res_zone    <= w_start ? 4'(r_zidx) : 4'd0;
            r_res_offset  <= w_start ? (8'(r_note) - 8'(r_zroot)) : 8'd0;
            r_res_count   <= 5'(w_vcnt[VOICES-1] + CW'(w_start && w_vtok[VOICES-1].idle));
        end
        if ((r_state == S_EMIT) && (!r_ovalid || o_out.ready)) begin
            r_o_started <= r_res_started;
            r_o_stolen  <= r_res_stolen;
            r_o_voice   <= r_res_voice;
            r_o_zone    <= r_res_zone;
            r_o_offset  <= r_res_offset;
            r_o_gain    <= r_res_started ? r_gain : 16'd0;
            r_o_mask    <= r_mask;
            r_o_count   <= r_res_count;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.started         = r_o_started;
    assign o_out.stolen          = r_o_stolen;
    assign o_out.voice_out       = r_o_voice;
    assign o_out.zone_out        = r_o_zone;
    assign o_out.semitone_offset = r_o_offset;
    assign o_out.voice_gain      = r_o_gain;
    assign o_out.stopped_mask    = r_o_mask;
    assign o_out.active_count    = r_o_count;

    `KZA_ASSERT_IMPL(a_zone_done_state, i_clk, i_rst_n, w_zdone, r_state == S_ZONE, "zone token outside zone scan")
    `KZA_ASSERT_IMPL(a_voice_done_state, i_clk, i_rst_n, w_vdone, r_state == S_VOICE, "voice token outside voice scan")
    `KZA_ASSERT_IMPL(a_steal_needs_start, i_clk, i_rst_n, o_out.valid && o_out.stolen, o_out.started, "steal without start")
    `KZA_ASSERT_IMPL(a_mask_no_start, i_clk, i_rst_n, o_out.valid && (o_out.stopped_mask != 16'd0), !o_out.started, "mask on a started item")
    `KZA_ASSERT_NEXT(a_age_step, i_clk, i_rst_n, (r_state == S_VOICE) && w_vdone && w_start, r_age_ctr == $past(r_age_ctr) + 32'd1, "age counter did not advance")

endmodule

// ===== sim/keyzone_voice_allocator_core_test.sv =====
`timescale 1ns / 100ps

module keyzone_voice_allocator_core_test;

    localparam int NVOICE      = 16;
    localparam int NZONE       = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 70;

    typedef struct {
        logic [1:0]  command;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [3:0]  finished_voice;
        logic [3:0]  zone_slot;
        logic [6:0]  zone_low;
        logic [6:0]  zone_high;
        logic [6:0]  zone_root;
        logic [15:0] zone_gain;
        logic        zone_src;
    } t_note_event;

    typedef struct packed {
        logic              started;
        logic              stolen;
        logic [3:0]        voice;
        logic [3:0]        zone;
        logic signed [7:0] offset;
        logic [15:0]       gain;
        logic [15:0]       mask;
        logic [4:0]        count;
    } t_voice_report;

    typedef enum bit {ROW_ITEM, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        t_note_event   ev;
        logic          reg_sel;
        logic [4:0]    value;
        bit            checked;
        t_voice_report want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kza_in_if  in_if();
    kza_out_if out_if();

    keyzone_voice_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    logic [6:0]  voice_note [NVOICE];
    bit          voice_busy [NVOICE];
    logic [31:0] voice_age [NVOICE];
    logic [31:0] age_count;
    logic [6:0]  zlow [NZONE];
    logic [6:0]  zhigh [NZONE];
    logic [6:0]  zroot [NZONE];
    logic [15:0] zgain [NZONE];
    bit          zsrc [NZONE];
    bit          zone_written [NZONE];
    int unsigned voices_cfg;
    int unsigned zones_cfg;

    t_voice_report pending_reports[$];
    t_stim_row     directed_rows[$];
    int            failures;
    int            items_sent;
    int            reports_checked;
    int            notes_started;
    int            notes_stolen;
    int            cycles;
    bit            calm;
    int            ready_hold;

    function automatic t_voice_report predict_allocation(input t_note_event ev);
        t_voice_report r;
        int nv;
        int nz;
        int best;
        int narrow_width;
        int v;
        int i;
        int cnt;
        r = '0;
        nv = (voices_cfg > NVOICE) ? NVOICE : int'(voices_cfg);
        if (nv == 0) nv = 1;
        nz = (zones_cfg > NZONE) ? NZONE : int'(zones_cfg);
        case (ev.command)
            kza_pkg::CMD_NOTE_ON: begin
                best = -1;
                narrow_width = 'h7FFF;
                for (i = 0; i < nz; i++) begin
                    if (ev.note >= zlow[i] && ev.note <= zhigh[i] &&
                        int'(zhigh[i]) - int'(zlow[i]) < narrow_width) begin
                        best = i;
                        narrow_width = int'(zhigh[i]) - int'(zlow[i]);
                    end
                end
                if (best >= 0 && zsrc[best]) begin
                    v = nv;
                    for (i = 0; i < nv; i++) begin
                        if (v == nv && !voice_busy[i]) v = i;
                    end
                    if (v == nv) begin
                        v = 0;
                        for (i = 1; i < nv; i++) begin
                            if (voice_age[i] < voice_age[v]) v = i;
                        end
                    end
                    r.stolen = voice_busy[v];
                    age_count = age_count + 32'd1;
                    voice_note[v] = ev.note;
                    voice_busy[v] = 1'b1;
                    voice_age[v] = age_count;
                    r.started = 1'b1;
                    r.voice = 4'(v);
                    r.zone = 4'(best);
                    r.offset = 8'(int'(ev.note) - int'(zroot[best]));
                    r.gain = 16'((32'(zgain[best]) * 32'(ev.velocity)) / 32'd127);
                    notes_started++;
                    if (r.stolen) notes_stolen++;
                end
            end
            kza_pkg::CMD_NOTE_OFF: begin
                for (i = 0; i < nv; i++) begin
                    if (voice_busy[i] && voice_note[i] == ev.note) begin
                        voice_busy[i] = 1'b0;
                        r.mask[i] = 1'b1;
                    end
                end
            end
            kza_pkg::CMD_VOICE_DONE: begin
                if (int'(ev.finished_voice) < nv) voice_busy[ev.finished_voice] = 1'b0;
            end
            default: begin
                zlow[ev.zone_slot] = ev.zone_low;
                zhigh[ev.zone_slot] = ev.zone_high;
                zroot[ev.zone_slot] = ev.zone_root;
                zgain[ev.zone_slot] = ev.zone_gain;
                zsrc[ev.zone_slot] = ev.zone_src;
                zone_written[ev.zone_slot] = 1'b1;
            end
        endcase
        cnt = 0;
        for (i = 0; i < nv; i++) cnt += voice_busy[i];
        r.count = 5'(cnt);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < NZONE && zone_written[n]) n++;
        return n;
    endfunction

    function automatic t_note_event make_event(input logic [1:0] command, input int note,
                                               input int velocity, input int fin);
        t_note_event ev;
        ev = '{default: '0};
        ev.command = command;
        ev.note = 7'(note);
        ev.velocity = 7'(velocity);
        ev.finished_voice = 4'(fin);
        return ev;
    endfunction

    function automatic t_note_event zone_event(input int slot, input int lo, input int hi,
                                               input int root, input int gain, input bit src);
        t_note_event ev;
        ev = make_event(kza_pkg::CMD_WRITE_ZONE, 0, 0, 0);
        ev.zone_slot = 4'(slot);
        ev.zone_low = 7'(lo);
        ev.zone_high = 7'(hi);
        ev.zone_root = 7'(root);
        ev.zone_gain = 16'(gain);
        ev.zone_src = src;
        return ev;
    endfunction

    function automatic t_note_event random_event();
        t_note_event ev;
        int r;
        int v;
        r = $urandom_range(0, 99);
        ev.note = 7'($urandom_range(0, 127));
        ev.velocity = 7'($urandom_range(0, 127));
        ev.finished_voice = 4'($urandom_range(0, 15));
        ev.zone_slot = 4'($urandom_range(0, 15));
        ev.zone_low = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 6) == 0) ev.zone_high = 7'($urandom_range(0, 127));
        else ev.zone_high = 7'(int'(ev.zone_low) + $urandom_range(0, 127 - int'(ev.zone_low)) /
                               $urandom_range(1, 4));
        ev.zone_root = 7'($urandom_range(0, 127));
        ev.zone_gain = 16'($urandom_range(0, 65535));
        ev.zone_src = ($urandom_range(0, 7) != 0);
        if (r < 45) ev.command = kza_pkg::CMD_NOTE_ON;
        else if (r < 65) ev.command = kza_pkg::CMD_NOTE_OFF;
        else if (r < 80) ev.command = kza_pkg::CMD_VOICE_DONE;
        else ev.command = kza_pkg::CMD_WRITE_ZONE;
        if (ev.command == kza_pkg::CMD_NOTE_OFF) begin
            v = $urandom_range(0, NVOICE - 1);
            if (voice_busy[v] && $urandom_range(0, 3) != 0) ev.note = voice_note[v];
        end
        return ev;
    endfunction

    function automatic t_voice_report report(input bit started, input bit stolen, input int v,
                                             input int z, input int off, input int gain,
                                             input int mask, input int cnt);
        t_voice_report r;
        r.started = started;
        r.stolen = stolen;
        r.voice = 4'(v);
        r.zone = 4'(z);
        r.offset = 8'(off);
        r.gain = 16'(gain);
        r.mask = 16'(mask);
        r.count = 5'(cnt);
        return r;
    endfunction

    function automatic t_stim_row item_row(input t_note_event ev);
        t_stim_row row;
        row.kind = ROW_ITEM;
        row.ev = ev;
        row.reg_sel = 1'b0;
        row.value = '0;
        row.checked = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic t_stim_row checked_row(input t_note_event ev, input t_voice_report want);
        t_stim_row row;
        row = item_row(ev);
        row.checked = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_stim_row config_row(input logic reg_sel, input int value);
        t_stim_row row;
        row = item_row(make_event(kza_pkg::CMD_NOTE_ON, 0, 0, 0));
        row.kind = ROW_CONFIG;
        row.reg_sel = reg_sel;
        row.value = 5'(value);
        return row;
    endfunction

    task automatic send_event(input t_note_event ev, input bit checked,
                              input t_voice_report want);
        t_voice_report predicted;
        int gap;
        in_if.valid <= 1'b1;
        in_if.command <= ev.command;
        in_if.note <= ev.note;
        in_if.velocity <= ev.velocity;
        in_if.finished_voice <= ev.finished_voice;
        in_if.zone_slot <= ev.zone_slot;
        in_if.zone_low_note <= ev.zone_low;
        in_if.zone_high_note <= ev.zone_high;
        in_if.zone_root_note <= ev.zone_root;
        in_if.zone_gain_in <= ev.zone_gain;
        in_if.zone_has_source <= ev.zone_src;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predicted = predict_allocation(ev);
        pending_reports.push_back(checked ? want : predicted);
        items_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_reports();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [4:0] value);
        drain_reports();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (reg_sel == kza_pkg::REG_VOICES_IN_USE) voices_cfg = value;
        else zones_cfg = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (calm || $urandom_range(0, 1) == 1) begin
            out_if.ready <= 1'b1;
            ready_hold = $urandom_range(0, 8);
        end else begin
            out_if.ready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_voice_report want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                failures++;
                $display("%0t: result arrived with no item outstanding", $time);
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                compare_field("started", want.started, out_if.started);
                compare_field("stolen", want.stolen, out_if.stolen);
                compare_field("voice_out", want.voice, out_if.voice_out);
                compare_field("zone_out", want.zone, out_if.zone_out);
                compare_field("semitone_offset", want.offset, out_if.semitone_offset);
                compare_field("voice_gain", want.gain, out_if.voice_gain);
                compare_field("stopped_mask", want.mask, out_if.stopped_mask);
                compare_field("active_count", want.count, out_if.active_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_reports.size());
            $display("FAIL keyzone_voice_allocator_core");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int slot;
        int vsel;
        t_note_event ev;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.command = kza_pkg::CMD_NOTE_ON;
        in_if.note = '0;
        in_if.velocity = '0;
        in_if.finished_voice = '0;
        in_if.zone_slot = '0;
        in_if.zone_low_note = '0;
        in_if.zone_high_note = '0;
        in_if.zone_root_note = '0;
        in_if.zone_gain_in = '0;
        in_if.zone_has_source = 1'b0;
        out_if.ready = 1'b0;
        ready_hold = 0;
        calm = 1'b0;
        failures = 0;
        items_sent = 0;
        reports_checked = 0;
        notes_started = 0;
        notes_stolen = 0;
        cycles = 0;
        age_count = '0;
        voices_cfg = kza_pkg::VOICES_RESET;
        zones_cfg = kza_pkg::ZONES_RESET;
        for (slot = 0; slot < NVOICE; slot++) begin
            voice_note[slot] = '0;
            voice_busy[slot] = 1'b0;
            voice_age[slot] = '0;
        end
        for (slot = 0; slot < NZONE; slot++) begin
            zlow[slot] = '0;
            zhigh[slot] = '0;
            zroot[slot] = '0;
            zgain[slot] = '0;
            zsrc[slot] = 1'b0;
            zone_written[slot] = 1'b0;
        end

        // With no zones searched, nothing can start.
        directed_rows.push_back(checked_row(make_event(kza_pkg::CMD_NOTE_ON, 60, 100, 0),
                                            report(0, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(checked_row(make_event(kza_pkg::CMD_NOTE_OFF, 0, 0, 0),
                                            report(0, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(checked_row(make_event(kza_pkg::CMD_VOICE_DONE, 0, 0, 15),
                                            report(0, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(checked_row(zone_event(0, 0, 127, 60, 'hFFFF, 1),
                                            report(0, 0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(item_row(zone_event(1, 60, 72, 64, 'h4000, 1)));
        directed_rows.push_back(item_row(zone_event(2, 100, 90, 0, 'hAAAA, 1)));
        directed_rows.push_back(item_row(zone_event(3, 36, 47, 127, 'h5555, 0)));
        directed_rows.push_back(item_row(zone_event(4, 60, 72, 0, 'h1234, 1)));
        directed_rows.push_back(config_row(kza_pkg::REG_ZONES_IN_USE, 5));
        directed_rows.push_back(checked_row(make_event(kza_pkg::CMD_NOTE_ON, 127, 127, 0),
                                            report(1, 0, 0, 0, 67, 'hFFFF, 0, 1)));
        directed_rows.push_back(checked_row(make_event(kza_pkg::CMD_NOTE_ON, 0, 0, 0),
                                            report(1, 0, 1, 0, -60, 0, 0, 2)));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_NOTE_ON, 40, 64, 0)));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_NOTE_ON, 95, 80, 0)));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_NOTE_ON, 66, 1, 0)));
        directed_rows.push_back(config_row(kza_pkg::REG_VOICES_IN_USE, 1));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_NOTE_ON, 70, 90, 0)));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_VOICE_DONE, 0, 0, 5)));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_NOTE_OFF, 70, 0, 0)));
        directed_rows.push_back(config_row(kza_pkg::REG_VOICES_IN_USE, 16));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_NOTE_ON, 66, 127, 0)));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_NOTE_ON, 66, 50, 0)));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_NOTE_OFF, 66, 0, 0)));
        directed_rows.push_back(item_row(make_event(kza_pkg::CMD_VOICE_DONE, 0, 0, 1)));
        directed_rows.push_back(item_row(zone_event(15, 127, 127, 0, 'hFFFF, 1)));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CONFIG)
                write_register(directed_rows[k].reg_sel, directed_rows[k].value);
            else
                send_event(directed_rows[k].ev, directed_rows[k].checked, directed_rows[k].want);
        end

        for (phase = 0; phase < 6; phase++) begin
            if (phase == 3) begin
                for (slot = 0; slot < NZONE; slot++) begin
                    if (!zone_written[slot]) begin
                        ev = random_event();
                        ev.command = kza_pkg::CMD_WRITE_ZONE;
                        ev.zone_slot = 4'(slot);
                        send_event(ev, 1'b0, '0);
                    end
                end
            end
            case (phase)
                0: vsel = 4;
                1: vsel = 16;
                2: vsel = 1;
                3: vsel = 16;
                4: vsel = ($urandom_range(0, 1) == 1) ? 0 : 31;
                default: vsel = $urandom_range(2, 15);
            endcase
            write_register(kza_pkg::REG_VOICES_IN_USE, 5'(vsel));
            if (phase == 3) write_register(kza_pkg::REG_ZONES_IN_USE, 5'd16);
            else if (phase == 4) write_register(kza_pkg::REG_ZONES_IN_USE, 5'd31);
            else write_register(kza_pkg::REG_ZONES_IN_USE,
                                5'($urandom_range(0, written_prefix())));
            calm = (phase == 1 || phase == 4);
            repeat (PHASE_ITEMS) send_event(random_event(), 1'b0, '0);
        end

        calm = 1'b0;
        drain_reports();
        repeat (2 * NVOICE + NZONE) @(negedge i_clk);

        $display("Sent %0d items and checked %0d results over several pool and zone sizes.",
                 items_sent, reports_checked);
        $display("Notes started: %0d, of which %0d took a voice from an older note.",
                 notes_started, notes_stolen);
        if (failures == 0 && pending_reports.size() == 0) begin
            $display("PASS keyzone_voice_allocator_core");
        end else begin
            $display("FAIL keyzone_voice_allocator_core");
        end
        $finish;
    end

endmodule
